### rtl/core/file_handle_table_core_assert.svh
// ----------------------------------------------------------------------------
// File handle table assertion macros
// Shared concurrent assertion forms for the file handle table checkers.
// ----------------------------------------------------------------------------
`ifndef FILE_HANDLE_TABLE_CORE_ASSERT_SVH
`define FILE_HANDLE_TABLE_CORE_ASSERT_SVH

// same-cycle implication
`define FHT_ASSERT_IMP(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("file handle table check failed");

// next-cycle implication
`define FHT_ASSERT_NXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("file handle table check failed");

// fixed-delay implication
`define FHT_ASSERT_DLY(name, clk, rst_n, ante, dly, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##dly (cons)) \
    else $error("file handle table check failed");

`endif

### rtl/core/fht_pkg.sv
// ----------------------------------------------------------------------------
// File handle table package
// Request and response types, codes and controller commands.
// ----------------------------------------------------------------------------
package fht_pkg;

  localparam int unsigned SECTOR_SHIFT = 11;
  localparam int unsigned OFFSET_W     = 44;
  localparam int unsigned HANDLE_W     = 8;
  localparam int unsigned SLOT_OUT_W   = 5;

  typedef enum logic [1:0] {
    KIND_OPEN  = 2'd0,
    KIND_CLOSE = 2'd1,
    KIND_READ  = 2'd2,
    KIND_SEEK  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ORG_START = 2'd0,
    ORG_CUR   = 2'd1,
    ORG_END   = 2'd2,
    ORG_BAD   = 2'd3
  } origin_e;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_NOINIT     = 3'd1,
    ST_BADHANDLE  = 3'd2,
    ST_NOTFOUND   = 3'd3,
    ST_FULL       = 3'd4,
    ST_BADORIGIN  = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_CALC,
    S_EXEC,
    S_DONE
  } state_e;

  typedef struct packed {
    kind_e                 kind;
    logic [HANDLE_W-1:0]   handle;
    logic                  file_found;
    logic [31:0]           file_lba;
    logic [31:0]           file_size;
    logic [31:0]           byte_count;
    logic [31:0]           seek_offset;
    origin_e               origin;
  } req_t;

  typedef struct packed {
    status_e               status;
    logic [SLOT_OUT_W-1:0] slot;
    logic [OFFSET_W-1:0]   byte_offset;
    logic [31:0]           granted_bytes;
    logic [31:0]           new_position;
  } rsp_t;

  typedef struct packed {
    logic cap;
    logic rd;
    logic calc;
    logic exec;
  } cmd_t;

endpackage

### rtl/core/fht_ctrl.sv
// ----------------------------------------------------------------------------
// File handle table controller
// Sequences capture, table read, arithmetic and write-back for one item.
// ----------------------------------------------------------------------------
module fht_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  output logic          done_o,
  output fht_pkg::cmd_t cmd_o
);
  import fht_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    busy    = 1'b1;
    done_o  = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        busy      = 1'b0;
        cmd_o.cap = start;
        if (start) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_CALC;
      end
      S_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = S_EXEC;
      end
      S_EXEC: begin
        cmd_o.exec = 1'b1;
        state_d    = S_DONE;
      end
      S_DONE: begin
        done_o  = 1'b1;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/fht_dp.sv
// ----------------------------------------------------------------------------
// File handle table datapath
// Slot tables, free-slot encoder, read clamp and seek arithmetic.
// ----------------------------------------------------------------------------
module fht_dp #(
  parameter int unsigned SLOTS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  fht_pkg::cmd_t cmd_i,
  input  fht_pkg::req_t req_i,
  input  logic          cfg_valid_i,
  input  logic          cfg_data_i,
  output fht_pkg::rsp_t rsp_o
);
  import fht_pkg::*;

  localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CMP_W  = HANDLE_W + 1;

  logic              enabled_q;
  logic [SLOTS-1:0]  in_use_q;
  logic [SLOT_W-1:0] free_q, free_d;
  logic              full_q, full_d;

  logic [31:0] sec_mem [SLOTS];
  logic [31:0] len_mem [SLOTS];
  logic [31:0] pos_mem [SLOTS];

  req_t        req_q;
  rsp_t        rsp_q, rsp_d;
  logic [31:0] sec_q, len_q, pos_q;
  logic        hok_q;
  logic [31:0] left_q, posc_q, tgt_q;
  logic        past_q;
  logic [OFFSET_W-1:0] boff_q;

  logic [SLOT_W-1:0] idx;
  logic [31:0]       base;
  logic              open_we, pos_we, use_set, use_clr;
  logic [SLOT_W-1:0] pos_wa;
  logic [31:0]       pos_wd;
  logic [31:0]       clamp;
  logic [7:0]        free_ext;

  assign idx      = req_q.handle[SLOT_W-1:0];
  assign free_ext = 8'(free_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= 1'b0;
    end else if (cfg_valid_i) begin
      enabled_q <= cfg_data_i;
    end
  end

  always_comb begin
    free_d = '0;
    full_d = 1'b1;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!in_use_q[i]) begin
        free_d = SLOT_W'(i);
        full_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_use_q <= '0;
      free_q   <= '0;
      full_q   <= 1'b0;
    end else begin
      free_q <= free_d;
      full_q <= full_d;
      if (use_set) begin
        in_use_q[free_q] <= 1'b1;
      end
      if (use_clr) begin
        in_use_q[idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (open_we) begin
      sec_mem[free_q] <= req_q.file_lba;
      len_mem[free_q] <= req_q.file_size;
    end
    if (pos_we) begin
      pos_mem[pos_wa] <= pos_wd;
    end
    if (cmd_i.rd) begin
      sec_q <= sec_mem[idx];
      len_q <= len_mem[idx];
      pos_q <= pos_mem[idx];
    end
  end

  always_comb begin
    case (req_q.origin)
      ORG_CUR: base = pos_q;
      ORG_END: base = len_q;
      default: base = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      req_q <= req_i;
    end
    if (cmd_i.rd) begin
      hok_q <= ({1'b0, req_q.handle} < CMP_W'(SLOTS)) && in_use_q[idx];
    end
    if (cmd_i.calc) begin
      left_q <= len_q - pos_q;
      past_q <= !(pos_q < len_q);
      boff_q <= OFFSET_W'({sec_q, SECTOR_SHIFT'(0)}) + OFFSET_W'(pos_q);
      posc_q <= pos_q + req_q.byte_count;
      tgt_q  <= base + req_q.seek_offset;
    end
    if (cmd_i.exec) begin
      rsp_q <= rsp_d;
    end
  end

  assign clamp = (tgt_q > len_q) ? len_q : tgt_q;

  always_comb begin
    rsp_d         = '0;
    rsp_d.status  = ST_OK;
    open_we       = 1'b0;
    pos_we        = 1'b0;
    use_set       = 1'b0;
    use_clr       = 1'b0;
    pos_wa        = idx;
    pos_wd        = '0;
    if (!enabled_q) begin
      rsp_d.status = ST_NOINIT;
    end else if (req_q.kind == KIND_OPEN) begin
      if (!req_q.file_found) begin
        rsp_d.status = ST_NOTFOUND;
      end else if (full_q) begin
        rsp_d.status = ST_FULL;
      end else begin
        open_we    = cmd_i.exec;
        pos_we     = cmd_i.exec;
        use_set    = cmd_i.exec;
        pos_wa     = free_q;
        rsp_d.slot = free_ext[SLOT_OUT_W-1:0];
      end
    end else if (!hok_q) begin
      rsp_d.status = ST_BADHANDLE;
    end else if (req_q.kind == KIND_CLOSE) begin
      use_clr = cmd_i.exec;
    end else if (req_q.kind == KIND_READ) begin
      if (!past_q) begin
        pos_we            = cmd_i.exec;
        rsp_d.byte_offset = boff_q;
        if (req_q.byte_count >= left_q) begin
          rsp_d.granted_bytes = left_q;
          pos_wd              = len_q;
        end else begin
          rsp_d.granted_bytes = req_q.byte_count;
          pos_wd              = posc_q;
        end
      end
    end else begin
      if (req_q.origin == ORG_BAD) begin
        rsp_d.status = ST_BADORIGIN;
      end else begin
        pos_we             = cmd_i.exec;
        pos_wd             = clamp[31] ? '0 : clamp;
        rsp_d.new_position = pos_wd;
      end
    end
  end

  assign rsp_o = rsp_q;

endmodule

### rtl/core/file_handle_table_core.sv
// ----------------------------------------------------------------------------
// File handle table core
// Open-file slot table serving open, close, read and seek requests.
// ----------------------------------------------------------------------------
// channel   ports                              transfer
// request   start, busy, req_i                 start high and busy low
// result    done_o, rsp_o                      one-cycle strobe, no stall
// config    cfg_valid_i, cfg_ready_o, cfg_data_i  valid and ready high
//
// After accept an item passes through a table read, an arithmetic step and
// a write-back, then the result strobe, all on a single slot port.
// busy stays high through the result cycle; the next item enters after it.
// Reset clears all slots to free and the enable register to zero.
// ----------------------------------------------------------------------------
module file_handle_table_core #(
  parameter int unsigned SLOTS = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  fht_pkg::req_t req_i,
  output logic          done_o,
  output fht_pkg::rsp_t rsp_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic          cfg_data_i
);
  import fht_pkg::*;

  cmd_t cmd;

  assign cfg_ready_o = 1'b1;

  fht_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .done_o (done_o),
    .cmd_o  (cmd)
  );

  fht_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .req_i       (req_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .rsp_o       (rsp_o)
  );

endmodule

### rtl/core/fht_chk.sv
// ----------------------------------------------------------------------------
// File handle table checker
// Port-level timing checks, bound to the core.
// ----------------------------------------------------------------------------
`include "file_handle_table_core_assert.svh"

module fht_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic start,
  input logic busy,
  input logic done_o
);

  `FHT_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, start && !busy, busy)
  `FHT_ASSERT_DLY(a_result_latency, clk_i, rst_ni, start && !busy, 4, done_o)
  `FHT_ASSERT_NXT(a_done_single, clk_i, rst_ni, done_o, !done_o && !busy)
  `FHT_ASSERT_IMP(a_done_in_busy, clk_i, rst_ni, done_o, busy)

endmodule

bind file_handle_table_core fht_chk u_fht_chk (
  .clk_i  (clk_i),
  .rst_ni (rst_ni),
  .start  (start),
  .busy   (busy),
  .done_o (done_o)
);

### tb/tb_file_handle_table_core.sv
// ----------------------------------------------------------------------------
// File handle table core testbench
// Drives open, close, read and seek requests through the request port and
// toggles the enable register between phases. A shadow of the slot table
// predicts every response, and the monitor compares each strobed response
// field by field, in order. Directed requests cover the edge cases; random
// phases then fill, drain and exercise the table under varied idle gaps.
// ----------------------------------------------------------------------------
module tb_file_handle_table_core;
  import fht_pkg::*;

  localparam int unsigned SLOTS       = 32;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned MAX_REPORTS = 10;

  logic  clk_i       = 1'b0;
  logic  rst_ni      = 1'b0;
  logic  start       = 1'b0;
  logic  busy;
  req_t  req_i       = '0;
  logic  done_o;
  rsp_t  rsp_o;
  logic  cfg_valid_i = 1'b0;
  logic  cfg_ready_o;
  logic  cfg_data_i  = 1'b0;

  logic        slot_used     [SLOTS] = '{default: 1'b0};
  logic [31:0] slot_sector   [SLOTS] = '{default: '0};
  logic [31:0] slot_length   [SLOTS] = '{default: '0};
  logic [31:0] slot_position [SLOTS] = '{default: '0};
  logic        enable_shadow = 1'b0;

  req_t        request_backlog [$];
  rsp_t        awaited_responses [$];
  rsp_t        next_response;
  int unsigned gap_left       = 0;
  logic        gaps_on        = 1'b1;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count    = 0;

  file_handle_table_core #(
    .SLOTS(SLOTS)
  ) i_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .done_o     (done_o),
    .rsp_o      (rsp_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  function automatic rsp_t apply_to_table(input req_t rq);
    rsp_t        rs;
    int unsigned free_idx;
    logic [4:0]  h;
    logic [31:0] tgt;
    logic [31:0] remain;
    rs        = '0;
    rs.status = ST_OK;
    h         = rq.handle[4:0];
    free_idx  = SLOTS;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!slot_used[i]) free_idx = i;
    end
    if (!enable_shadow) begin
      rs.status = ST_NOINIT;
    end else if (rq.kind == KIND_OPEN) begin
      if (!rq.file_found) begin
        rs.status = ST_NOTFOUND;
      end else if (free_idx >= SLOTS) begin
        rs.status = ST_FULL;
      end else begin
        slot_used[free_idx]     = 1'b1;
        slot_sector[free_idx]   = rq.file_lba;
        slot_length[free_idx]   = rq.file_size;
        slot_position[free_idx] = '0;
        rs.slot                 = SLOT_OUT_W'(free_idx);
      end
    end else if (rq.handle >= SLOTS || !slot_used[h]) begin
      rs.status = ST_BADHANDLE;
    end else if (rq.kind == KIND_CLOSE) begin
      slot_used[h] = 1'b0;
    end else if (rq.kind == KIND_READ) begin
      if (slot_position[h] < slot_length[h]) begin
        remain           = slot_length[h] - slot_position[h];
        rs.granted_bytes = (rq.byte_count >= remain) ? remain : rq.byte_count;
        rs.byte_offset   = (OFFSET_W'(slot_sector[h]) << SECTOR_SHIFT)
                           + OFFSET_W'(slot_position[h]);
        slot_position[h] = slot_position[h] + rs.granted_bytes;
      end
    end else begin
      case (rq.origin)
        ORG_START: tgt = rq.seek_offset;
        ORG_CUR:   tgt = slot_position[h] + rq.seek_offset;
        ORG_END:   tgt = slot_length[h] + rq.seek_offset;
        default:   tgt = '0;
      endcase
      if (rq.origin == ORG_BAD) begin
        rs.status = ST_BADORIGIN;
      end else begin
        if (tgt > slot_length[h]) tgt = slot_length[h];
        if (tgt[31]) tgt = '0;
        slot_position[h] = tgt;
        rs.new_position  = tgt;
      end
    end
    return rs;
  endfunction

  function automatic req_t make_req(input kind_e k, input logic [7:0] h, input logic found,
                                    input logic [31:0] lba, input logic [31:0] size,
                                    input logic [31:0] count, input logic [31:0] offs,
                                    input origin_e org);
    req_t rq;
    rq.kind        = k;
    rq.handle      = h;
    rq.file_found  = found;
    rq.file_lba    = lba;
    rq.file_size   = size;
    rq.byte_count  = count;
    rq.seek_offset = offs;
    rq.origin      = org;
    return rq;
  endfunction

  function automatic req_t rand_request(input int unsigned w_open, input int unsigned w_close,
                                        input int unsigned w_read);
    req_t        rq;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < w_open) rq.kind = KIND_OPEN;
    else if (r < w_open + w_close) rq.kind = KIND_CLOSE;
    else if (r < w_open + w_close + w_read) rq.kind = KIND_READ;
    else rq.kind = KIND_SEEK;
    r = $urandom_range(0, 99);
    if (r < 50) rq.handle = 8'($urandom_range(0, 7));
    else if (r < 85) rq.handle = 8'($urandom_range(0, SLOTS - 1));
    else rq.handle = 8'($urandom_range(0, 255));
    rq.file_found = ($urandom_range(0, 9) != 0);
    case ($urandom_range(0, 3))
      0:       rq.file_lba = $urandom();
      1:       rq.file_lba = $urandom_range(0, 1000);
      2:       rq.file_lba = '0;
      default: rq.file_lba = '1;
    endcase
    r = $urandom_range(0, 9);
    if (r < 4) rq.file_size = $urandom_range(0, 300);
    else if (r < 7) rq.file_size = $urandom();
    else if (r < 8) rq.file_size = '0;
    else if (r < 9) rq.file_size = '1;
    else rq.file_size = 32'h7FFF_FFE0 + $urandom_range(0, 64);
    r = $urandom_range(0, 9);
    if (r < 5) rq.byte_count = $urandom_range(0, 100);
    else if (r < 8) rq.byte_count = $urandom();
    else rq.byte_count = '1;
    r = $urandom_range(0, 9);
    if (r < 3) rq.seek_offset = $urandom_range(0, 300);
    else if (r < 5) rq.seek_offset = ~32'($urandom_range(0, 19));
    else if (r < 9) rq.seek_offset = $urandom();
    else rq.seek_offset = 32'h7FFF_FFE0 + $urandom_range(0, 64);
    rq.origin = origin_e'($urandom_range(0, 3));
    return rq;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic wait_table_quiet();
    do @(posedge clk_i);
    while (request_backlog.size() != 0 || start || awaited_responses.size() != 0 || busy);
  endtask

  task automatic set_enable(input logic value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    enable_shadow = value;
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_phase(input logic en, input int unsigned w_open,
                           input int unsigned w_close, input int unsigned w_read,
                           input int unsigned n_items, input logic idle_gaps);
    wait_table_quiet();
    set_enable(en);
    gaps_on = idle_gaps;
    repeat (n_items) request_backlog.push_back(rand_request(w_open, w_close, w_read));
  endtask

  // hold start until accepted, then advance to the next item after its gap
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) begin
        awaited_responses.push_back(apply_to_table(req_i));
        gap_left = pick_gap();
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left = gap_left - 1;
          start <= 1'b0;
        end else if (request_backlog.size() != 0) begin
          start <= 1'b1;
          req_i <= request_backlog.pop_front();
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (awaited_responses.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected response: status %0d slot %0d", rsp_o.status, rsp_o.slot);
      end else begin
        next_response = awaited_responses.pop_front();
        if (rsp_o.status !== next_response.status || rsp_o.slot !== next_response.slot ||
            rsp_o.byte_offset !== next_response.byte_offset ||
            rsp_o.granted_bytes !== next_response.granted_bytes ||
            rsp_o.new_position !== next_response.new_position) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("mismatch (exp/act): status %0d/%0d slot %0d/%0d offset %h/%h granted %h/%h pos %h/%h",
                     next_response.status, rsp_o.status, next_response.slot, rsp_o.slot,
                     next_response.byte_offset, rsp_o.byte_offset,
                     next_response.granted_bytes, rsp_o.granted_bytes,
                     next_response.new_position, rsp_o.new_position);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    request_backlog.push_back(make_req(KIND_OPEN, 8'd0, 1'b1, 32'd5, 32'd100, '0, '0, ORG_START));
    request_backlog.push_back(make_req(KIND_CLOSE, 8'd0, 1'b0, '0, '0, '0, '0, ORG_START));
    request_backlog.push_back(make_req(KIND_READ, 8'd0, 1'b0, '0, '0, 32'd10, '0, ORG_START));
    request_backlog.push_back(make_req(KIND_SEEK, 8'd0, 1'b0, '0, '0, '0, 32'd3, ORG_CUR));
    wait_table_quiet();
    set_enable(1'b1);

    request_backlog.push_back(make_req(KIND_OPEN, 8'd0, 1'b0, '1, '1, '0, '0, ORG_START));
    request_backlog.push_back(make_req(KIND_OPEN, 8'd0, 1'b1, '1, '1, '0, '0, ORG_START));
    request_backlog.push_back(make_req(KIND_READ, 8'd0, 1'b0, '0, '0, '1, '0, ORG_START));
    request_backlog.push_back(make_req(KIND_READ, 8'd0, 1'b0, '0, '0, 32'd5, '0, ORG_START));
    request_backlog.push_back(make_req(KIND_SEEK, 8'd0, 1'b0, '0, '0, '0, 32'd7, ORG_START));
    request_backlog.push_back(make_req(KIND_SEEK, 8'd0, 1'b0, '0, '0, '0, 32'hFFFF_FFFB,
                                       ORG_CUR));
    request_backlog.push_back(make_req(KIND_SEEK, 8'd0, 1'b0, '0, '0, '0, 32'hFFFF_FFF3,
                                       ORG_END));
    request_backlog.push_back(make_req(KIND_SEEK, 8'd0, 1'b0, '0, '0, '0, '0, ORG_END));
    request_backlog.push_back(make_req(KIND_SEEK, 8'd0, 1'b0, '0, '0, '0, 32'd1, ORG_BAD));
    request_backlog.push_back(make_req(KIND_OPEN, 8'd0, 1'b1, '0, 32'd100, '0, '0, ORG_START));
    request_backlog.push_back(make_req(KIND_SEEK, 8'd1, 1'b0, '0, '0, '0, 32'd1000, ORG_START));
    request_backlog.push_back(make_req(KIND_SEEK, 8'd1, 1'b0, '0, '0, '0, 32'hFFFF_FFF9,
                                       ORG_CUR));
    request_backlog.push_back(make_req(KIND_READ, 8'd1, 1'b0, '0, '0, '0, '0, ORG_START));
    request_backlog.push_back(make_req(KIND_READ, 8'd1, 1'b0, '0, '0, 32'd10, '0, ORG_START));
    request_backlog.push_back(make_req(KIND_CLOSE, 8'd255, 1'b0, '0, '0, '0, '0, ORG_START));
    request_backlog.push_back(make_req(KIND_READ, 8'd32, 1'b0, '0, '0, 32'd1, '0, ORG_START));
    request_backlog.push_back(make_req(KIND_CLOSE, 8'd1, 1'b0, '0, '0, '0, '0, ORG_START));
    request_backlog.push_back(make_req(KIND_READ, 8'd1, 1'b0, '0, '0, 32'd1, '0, ORG_START));
    request_backlog.push_back(make_req(KIND_OPEN, 8'd0, 1'b1, 32'd9, '0, '0, '0, ORG_START));
    request_backlog.push_back(make_req(KIND_READ, 8'd1, 1'b0, '0, '0, 32'd4, '0, ORG_START));

    run_phase(1'b1, 30, 20, 25, 300, 1'b1);
    run_phase(1'b1, 70, 5, 15, 200, 1'b1);
    run_phase(1'b0, 25, 25, 25, 60, 1'b0);
    run_phase(1'b1, 10, 5, 45, 400, 1'b0);
    run_phase(1'b1, 10, 60, 15, 150, 1'b1);
    run_phase(1'b1, 30, 20, 25, 400, 1'b1);
    run_phase(1'b0, 25, 25, 25, 40, 1'b1);
    run_phase(1'b1, 70, 5, 15, 150, 1'b0);
    run_phase(1'b1, 25, 15, 30, 300, 1'b1);

    wait_table_quiet();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0 && awaited_responses.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

### file_handle_table_core.f
+incdir+rtl/core
rtl/core/fht_pkg.sv
rtl/core/fht_ctrl.sv
rtl/core/fht_dp.sv
rtl/core/file_handle_table_core.sv
rtl/core/fht_chk.sv
tb/tb_file_handle_table_core.sv
